FILE: rtl/core/lpb_pkg.sv
`default_nettype none
package lpb_pkg;
  localparam int ColorW = 24;
  localparam logic [1:0] ActBegin = 2'd0;
  localparam logic [1:0] ActPixel = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StAccept     = 3'd1;
  localparam logic [2:0] StWidth      = 3'd2;
  localparam logic [2:0] StHeight     = 3'd3;
  localparam logic [2:0] StColors     = 3'd4;
  localparam logic [2:0] StColorsFirst = 3'd5;
  localparam logic [2:0] StIgnored    = 3'd6;

  typedef struct packed {
    logic        vld;
    logic [17:0] key;
    logic        hit;
    logic [7:0]  idx;
  } lpb_probe_t;

  typedef struct packed {
    logic        wr;
    logic [7:0]  idx;
    logic [23:0] color;
  } lpb_write_t;
endpackage
`default_nettype wire

FILE: rtl/core/lpb_cell.sv
`default_nettype none
module lpb_cell #(
  parameter logic [7:0] Index = 8'd0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      clear_i,
  input  wire                      active_i,
  input  wire lpb_pkg::lpb_write_t wr_i,
  input  wire lpb_pkg::lpb_probe_t probe_i,
  output lpb_pkg::lpb_probe_t      probe_o,
  output logic [23:0]              color_o
);
  import lpb_pkg::*;

  logic [23:0] color_q;
  lpb_probe_t  probe_q, probe_d;
  logic        match;

  assign match = active_i &&
    ({color_q[23:18], color_q[15:10], color_q[7:2]} == probe_i.key);

  always_comb begin
    probe_d = probe_i;
    if (probe_i.vld && !probe_i.hit && match) begin
      probe_d.hit = 1'b1;
      probe_d.idx = Index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else if (clear_i) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr && wr_i.idx == Index) begin
      color_q <= wr_i.color;
    end
  end

  assign probe_o = probe_q;
  assign color_o = color_q;
endmodule
`default_nettype wire

FILE: rtl/core/lossy_palette_builder.sv
`default_nettype none
// Palette builder for vertically stacked image regions.
// Command channel: drive action_i and fields with start_i; the item is taken
// at a clock edge where start_i is high and busy_o is low.
// Actions: begin region, pixel, read palette entry.
// Result: one per item, on the result ports for one cycle with done_o high.
// Receiver cannot stall; the result must be taken in that cycle.
// Pixels walk a chain of PALETTE_SIZE cells, one cell per cycle, each holding
// one palette entry and comparing the top six bits of every channel.
// Order: a pixel that needs the palette search walks the whole chain in the
// walk state and then gives its result from the finish state; begin, read
// and ignored items go from the walk state straight to the finish state.
// busy_o drops with the result, so a new item can be taken in the cycle in
// which the result is shown. One item at a time.
// Reset clears counts, width, height and region state; palette entries stay
// undefined until written.
module lossy_palette_builder #(
  parameter int PALETTE_SIZE = 256,
  parameter int MAX_IMAGE_HEIGHT = 1024,
  parameter int MAX_IMAGE_WIDTH = 2048
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  input  wire [1:0]  action_i,
  input  wire [11:0] region_width_i,
  input  wire [10:0] region_height_i,
  input  wire [7:0]  red_i,
  input  wire [7:0]  green_i,
  input  wire [7:0]  blue_i,
  input  wire [7:0]  read_index_i,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic [7:0] pixel_index_o,
  output logic [8:0] color_count_o,
  output logic       region_done_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);
  import lpb_pkg::*;

  localparam int CntW = $clog2(PALETTE_SIZE + 3);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SWalk = 2'd1;
  localparam logic [1:0] SFin  = 2'd2;

  logic [1:0]  st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [8:0]  used_q, used_d, start_cnt_q, start_cnt_d;
  logic [11:0] width_q, width_d;
  logic [10:0] height_q, height_d, held_q, held_d;
  logic [21:0] left_q, left_d;
  logic        failed_q, failed_d;
  logic [1:0]  act_q;
  logic [23:0] pix_q;
  logic [7:0]  ridx_q;
  logic [11:0] w_q;
  logic [10:0] h_q;
  logic        done_d, rdone_d;
  logic [2:0]  status_d;
  logic [7:0]  pidx_d;
  logic [23:0] rgb_d;
  logic        clear;
  lpb_write_t  wr;
  lpb_probe_t  head;
  lpb_probe_t  chain [PALETTE_SIZE+1];
  logic [23:0] colors [PALETTE_SIZE];
  logic [21:0] area;
  logic [11:0] hsum;

  assign clear = (st_q == SIdle);
  assign head.vld = (st_q == SWalk) && (cnt_q == '0);
  assign head.key = {pix_q[23:18], pix_q[15:10], pix_q[7:2]};
  assign head.hit = 1'b0;
  assign head.idx = '0;
  assign chain[0] = head;

  for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
    lpb_cell #(.Index(8'(g))) u_cell (
      .clk_i, .rst_ni, .clear_i(clear),
      .active_i(used_q > 9'(g)),
      .wr_i(wr), .probe_i(chain[g]), .probe_o(chain[g+1]),
      .color_o(colors[g])
    );
  end

  assign area = 22'(w_q) * 22'(h_q);
  assign hsum = {1'b0, height_q} + {1'b0, h_q};

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; used_d = used_q; start_cnt_d = start_cnt_q;
    width_d = width_q; height_d = height_q; held_d = held_q; left_d = left_q;
    failed_d = failed_q;
    done_d = 1'b0; rdone_d = 1'b0; status_d = StOk; pidx_d = '0; rgb_d = '0;
    wr = '0;
    unique case (st_q)
      SIdle: begin
        if (start_i) begin
          st_d = SWalk;
          cnt_d = '0;
        end
      end
      SWalk: begin
        if (act_q == ActPixel && left_q != '0 && !failed_q) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(PALETTE_SIZE - 1)) st_d = SFin;
        end else begin
          st_d = SFin;
        end
      end
      default: begin
        st_d = SIdle;
        done_d = 1'b1;
        unique case (act_q)
          ActBegin: begin
            if ((width_q != '0 && w_q != width_q) || w_q > 12'(MAX_IMAGE_WIDTH)) begin
              left_d = '0; status_d = StWidth;
            end else if (hsum > 12'(MAX_IMAGE_HEIGHT)) begin
              left_d = '0; status_d = StHeight;
            end else begin
              start_cnt_d = used_q;
              if (width_q == '0) begin
                width_d = w_q; height_d = h_q;
              end else begin
                height_d = hsum[10:0];
              end
              held_d = h_q; failed_d = 1'b0; left_d = area;
              status_d = StAccept;
            end
          end
          ActPixel: begin
            if (left_q == '0) begin
              status_d = StIgnored;
            end else begin
              left_d = left_q - 1'b1;
              rdone_d = (left_q == 22'd1);
              if (failed_q) begin
                status_d = StIgnored;
              end else if (chain[PALETTE_SIZE].hit) begin
                pidx_d = chain[PALETTE_SIZE].idx;
              end else if (used_q >= 9'(PALETTE_SIZE)) begin
                used_d = start_cnt_q;
                height_d = height_q - held_q;
                failed_d = 1'b1;
                status_d = (start_cnt_q == '0) ? StColorsFirst : StColors;
              end else begin
                wr.wr = 1'b1; wr.idx = used_q[7:0]; wr.color = pix_q;
                pidx_d = used_q[7:0];
                used_d = used_q + 1'b1;
              end
            end
          end
          ActRead: begin
            if ({1'b0, ridx_q} < 9'(PALETTE_SIZE)) rgb_d = colors[ridx_q];
          end
          default: status_d = StIgnored;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; used_q <= '0; start_cnt_q <= '0;
      width_q <= '0; height_q <= '0; held_q <= '0; left_q <= '0;
      failed_q <= 1'b0; done_o <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; used_q <= used_d; start_cnt_q <= start_cnt_d;
      width_q <= width_d; height_q <= height_d; held_q <= held_d; left_q <= left_d;
      failed_q <= failed_d; done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && start_i) begin
      act_q <= action_i; pix_q <= {red_i, green_i, blue_i};
      ridx_q <= read_index_i; w_q <= region_width_i; h_q <= region_height_i;
    end
    status_o <= status_d; pixel_index_o <= pidx_d; color_count_o <= used_d;
    region_done_o <= rdone_d;
    {red_out_o, green_out_o, blue_out_o} <= rgb_d;
  end

  assign busy_o = (st_q != SIdle);
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import lpb_pkg::*;

  localparam logic [1:0] ActNone = 2'd3;
  localparam int ItemTarget = 1550;
  localparam int ImgW = 2;

  typedef struct {
    logic [1:0]  act;
    logic [11:0] w;
    logic [10:0] h;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  ri;
  } cmd_t;

  typedef struct {
    logic [2:0] status;
    logic [7:0] pix;
    logic [8:0] count;
    logic       rdone;
    logic [7:0] ro;
    logic [7:0] go;
    logic [7:0] bo;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  action_i = '0;
  logic [11:0] region_width_i = '0;
  logic [10:0] region_height_i = '0;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic [7:0]  read_index_i = '0;
  wire         busy_o;
  wire         done_o;
  wire  [2:0]  status_o;
  wire  [7:0]  pixel_index_o;
  wire  [8:0]  color_count_o;
  wire         region_done_o;
  wire  [7:0]  red_out_o;
  wire  [7:0]  green_out_o;
  wire  [7:0]  blue_out_o;

  lossy_palette_builder u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .action_i(action_i), .region_width_i(region_width_i),
    .region_height_i(region_height_i), .red_i(red_i), .green_i(green_i),
    .blue_i(blue_i), .read_index_i(read_index_i), .done_o(done_o),
    .status_o(status_o), .pixel_index_o(pixel_index_o),
    .color_count_o(color_count_o), .region_done_o(region_done_o),
    .red_out_o(red_out_o), .green_out_o(green_out_o), .blue_out_o(blue_out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  cmd_t    pending_items[$];
  answer_t expected_answers[$];
  int      n_taken = 0;
  int      n_fail = 0;

  logic [23:0] pal [256];
  logic [8:0]  colors_used = '0;
  logic [8:0]  colors_at_start = '0;
  logic [11:0] img_width = '0;
  logic [10:0] img_height = '0;
  logic [21:0] pixels_left = '0;
  logic        region_failed = 1'b0;
  logic [10:0] height_held = '0;
  int          peak_colors = 0;

  function automatic int find_key(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    for (int c = 0; c < int'(colors_used); c++) begin
      if (pal[c][23:18] == r[7:2] && pal[c][15:10] == g[7:2] && pal[c][7:2] == b[7:2])
        return c;
    end
    return -1;
  endfunction

  task automatic predict_palette(cmd_t c);
    answer_t a;
    int      hit;
    a = '{default: '0};
    case (c.act)
      ActBegin: begin
        if ((img_width != 0 && c.w != img_width) || c.w > 12'd2048) begin
          pixels_left = '0;
          a.status = StWidth;
        end else if (int'(img_height) + int'(c.h) > 1024) begin
          pixels_left = '0;
          a.status = StHeight;
        end else begin
          colors_at_start = colors_used;
          if (img_width == 0) begin
            img_width = c.w;
            img_height = c.h;
          end else begin
            img_height = img_height + c.h;
          end
          height_held = c.h;
          region_failed = 1'b0;
          pixels_left = 22'(c.w) * 22'(c.h);
          a.status = StAccept;
        end
      end
      ActPixel: begin
        if (pixels_left == 0) begin
          a.status = StIgnored;
        end else begin
          pixels_left = pixels_left - 22'd1;
          a.rdone = (pixels_left == 0);
          if (region_failed) begin
            a.status = StIgnored;
          end else begin
            hit = find_key(c.r, c.g, c.b);
            if (hit < 0 && colors_used >= 9'd256) begin
              colors_used = colors_at_start;
              img_height = img_height - height_held;
              region_failed = 1'b1;
              a.status = (colors_at_start == 0) ? StColorsFirst : StColors;
            end else begin
              if (hit < 0) begin
                pal[colors_used[7:0]] = {c.r, c.g, c.b};
                hit = int'(colors_used);
                colors_used = colors_used + 9'd1;
                if (int'(colors_used) > peak_colors) peak_colors = int'(colors_used);
              end
              a.status = StOk;
              a.pix = hit[7:0];
            end
          end
        end
      end
      ActRead: begin
        a.status = StOk;
        {a.ro, a.go, a.bo} = pal[c.ri];
      end
      default: a.status = StIgnored;
    endcase
    a.count = colors_used;
    expected_answers = {expected_answers, a};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_palette('{action_i, region_width_i, region_height_i, red_i, green_i,
                          blue_i, read_index_i});
        n_taken <= n_taken + 1;
      end
      if (!start_i || !busy_o) begin
        if (pending_items.size() > 0 &&
            ((n_taken > 500 && n_taken < 750) || $urandom_range(0, 99) >= 33)) begin
          cmd_t c;
          c = pending_items.pop_front();
          start_i <= 1'b1;
          action_i <= c.act;
          region_width_i <= c.w;
          region_height_i <= c.h;
          red_i <= c.r;
          green_i <= c.g;
          blue_i <= c.b;
          read_index_i <= c.ri;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        n_fail++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o); n_fail++;
        end
        if (pixel_index_o !== e.pix) begin
          $error("pixel_index expected %0d actual %0d", e.pix, pixel_index_o); n_fail++;
        end
        if (color_count_o !== e.count) begin
          $error("color_count expected %0d actual %0d", e.count, color_count_o); n_fail++;
        end
        if (region_done_o !== e.rdone) begin
          $error("region_done expected %0d actual %0d", e.rdone, region_done_o); n_fail++;
        end
        if (red_out_o !== e.ro) begin
          $error("red_out expected %0d actual %0d", e.ro, red_out_o); n_fail++;
        end
        if (green_out_o !== e.go) begin
          $error("green_out expected %0d actual %0d", e.go, green_out_o); n_fail++;
        end
        if (blue_out_o !== e.bo) begin
          $error("blue_out expected %0d actual %0d", e.bo, blue_out_o); n_fail++;
        end
      end
    end
  end

  int n_sent = 0;

  task automatic send(logic [1:0] act, int w, int h, int r, int g, int b, int ri);
    cmd_t c;
    c = '{act, 12'(w), 11'(h), 8'(r), 8'(g), 8'(b), 8'(ri)};
    while (pending_items.size() != 0) @(posedge clk_i);
    pending_items = {pending_items, c};
    n_sent++;
  endtask

  task automatic send_pixel();
    logic [23:0] col;
    col = 24'($urandom);
    if (peak_colors > 0 && $urandom_range(0, 99) < 60) begin
      col = pal[$urandom_range(0, peak_colors - 1)];
      col = col ^ {6'd0, 2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)};
    end
    send(ActPixel, $urandom, $urandom, int'(col[23:16]), int'(col[15:8]),
         int'(col[7:0]), $urandom);
  endtask

  task automatic send_read();
    if (peak_colors > 0)
      send(ActRead, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom_range(0, peak_colors - 1));
    else
      send(ActNone, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int h;
    int npix;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(ActNone, 4095, 2047, 255, 255, 255, 255);
    send(ActPixel, 0, 0, 18, 52, 86, 0);
    send(ActBegin, 0, 5, 0, 0, 0, 0);
    send(ActPixel, 0, 0, 1, 2, 3, 0);
    send(ActBegin, 2049, 1, 0, 0, 0, 0);
    send(ActBegin, 2, 2047, 0, 0, 0, 0);
    // first region with pixels overflows the palette
    send(ActBegin, 2, 150, 0, 0, 0, 0);
    for (int k = 0; k < 300; k++)
      send(ActPixel, 0, 0, int'({k[5:0], 2'($urandom)}), int'({k[11:6], 2'($urandom)}),
           $urandom, 0);
    send(ActBegin, 2, 1, 0, 0, 0, 0);
    send(ActPixel, 0, 0, 0, 0, 0, 0);
    send(ActRead, 0, 0, 0, 0, 0, 255);
    send(ActPixel, 0, 0, 255, 255, 255, 0);
    send(ActPixel, 0, 0, 3, 2, 1, 0);
    send(ActBegin, 3, 1, 0, 0, 0, 0);
    send(ActBegin, 2, 1024, 0, 0, 0, 0);
    send(ActBegin, 2, 1, 0, 0, 0, 0);
    send(ActPixel, 0, 0, 3, 2, 1, 0);
    send(ActRead, 0, 0, 0, 0, 0, 0);
    send(ActRead, 0, 0, 0, 0, 0, 1);

    while (n_sent < ItemTarget) begin
      if ($urandom_range(0, 99) < 75) begin
        h = $urandom_range(1, 3);
        npix = ImgW * h;
        if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, npix - 1);
        send(ActBegin, ImgW, h, $urandom, $urandom, $urandom, $urandom);
        for (int p = 0; p < npix; p++) begin
          if ($urandom_range(0, 99) < 20) send_read();
          send_pixel();
        end
      end else begin
        case ($urandom_range(0, 4))
          0: send(ActNone, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          1: send_pixel();
          2: begin
            h = $urandom_range(0, 4095);
            if (h == ImgW) h = ImgW + 1;
            send(ActBegin, h, $urandom, $urandom, $urandom, $urandom, $urandom);
          end
          3: send(ActBegin, ImgW, $urandom_range(1024, 2047), $urandom, $urandom,
                  $urandom, $urandom);
          default: send_read();
        endcase
      end
    end

    while (n_taken != n_sent || expected_answers.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("lossy_palette_builder: match");
    end else begin
      $display("lossy_palette_builder: mismatch");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("lossy_palette_builder: mismatch");
    $finish;
  end
endmodule
